>>> rtl/core/assert_macros.svh
// assertion macros for the midi file parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (c)) else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> rtl/core/mfsp_pkg.sv
// types and constants shared by the midi file parser
package mfsp_pkg;
  localparam int VarintMaxBytes = 4;

  localparam logic [4:0] PH_HDR_MAGIC  = 5'd0;
  localparam logic [4:0] PH_HDR_LEN    = 5'd1;
  localparam logic [4:0] PH_HDR_FORMAT = 5'd2;
  localparam logic [4:0] PH_HDR_NTRKS  = 5'd3;
  localparam logic [4:0] PH_HDR_DIV    = 5'd4;
  localparam logic [4:0] PH_HDR_SKIP   = 5'd5;
  localparam logic [4:0] PH_TRK_MAGIC  = 5'd6;
  localparam logic [4:0] PH_TRK_LEN    = 5'd7;
  localparam logic [4:0] PH_DELTA      = 5'd8;
  localparam logic [4:0] PH_STATUS     = 5'd9;
  localparam logic [4:0] PH_META_TYPE  = 5'd10;
  localparam logic [4:0] PH_META_LEN   = 5'd11;
  localparam logic [4:0] PH_TEMPO      = 5'd12;
  localparam logic [4:0] PH_META_SKIP  = 5'd13;
  localparam logic [4:0] PH_SYSEX_LEN  = 5'd14;
  localparam logic [4:0] PH_SYSEX_SKIP = 5'd15;
  localparam logic [4:0] PH_DATA1      = 5'd16;
  localparam logic [4:0] PH_DATA2      = 5'd17;
  localparam logic [4:0] PH_TAIL       = 5'd18;
  localparam logic [4:0] PH_DONE       = 5'd19;
  localparam logic [4:0] PH_REJECTED   = 5'd20;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0, KIND_TEMPO = 3'd1, KIND_TRACK_END = 3'd2,
    KIND_HEADER = 3'd3, KIND_FILE_OK = 3'd4, KIND_REJECTED = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ERR_HDR_MAGIC = 4'd0, ERR_SHORT_HDR = 4'd1, ERR_ZERO_TRACKS = 4'd2,
    ERR_DIVISION = 4'd3, ERR_TRK_MAGIC = 4'd4, ERR_OVERRUN = 4'd5,
    ERR_NO_EOT = 4'd6, ERR_LONG_VARINT = 4'd7, ERR_ZERO_TEMPO = 4'd8,
    ERR_NO_RUNNING = 4'd9, ERR_SYS_STATUS = 4'd10, ERR_DATA_HIGH = 4'd11,
    ERR_TRUNCATED = 4'd12
  } err_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] track_number;
    logic [31:0] tick_time;
    logic [7:0]  status_value;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_micros;
    logic [14:0] ticks_per_quarter;
    logic [15:0] track_total;
    logic [3:0]  error_code;
    logic        run_end;
  } res_t;

  // results caused by one byte, at most two
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  function automatic res_t mk_res(kind_e k, logic [15:0] trk, logic [31:0] tick);
    res_t r;
    r = '0;
    r.result_kind  = k;
    r.track_number = trk;
    r.tick_time    = tick;
    return r;
  endfunction
endpackage

>>> rtl/core/mfsp_stream_if.sv
// valid/ready channel interfaces
interface mfsp_in_if;
  logic valid;
  logic ready;
  mfsp_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfsp_out_if;
  logic valid;
  logic ready;
  mfsp_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/mfsp_decoder.sv
// byte decoder: parse state and result generation for one byte per cycle, advancing only while step_i is high
module mfsp_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  mfsp_pkg::in_t       in_i,
  output mfsp_pkg::res_pair_t res_o
);
  import mfsp_pkg::*;

  logic [4:0]  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] ntrk_q, ntrk_d;
  logic [15:0] trk_q, trk_d;
  logic [31:0] left_q, left_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  run_q, run_d;
  logic [7:0]  meta_q, meta_d;
  logic [7:0]  hstat_q, hstat_d;
  logic [6:0]  hdata_q, hdata_d;
  logic [14:0] div_q, div_d;

  res_pair_t rp;
  logic [7:0]  b;
  logic [2:0]  cnt_inc;
  logic [31:0] acc8, acc7;
  logic [15:0] trk_inc;
  logic [7:0]  hi;

  always_comb begin
    // state update helpers, kept as intermediate variables
    logic [7:0] mexp;
    logic       vdone, verr, evt_done, do_meta_end, take1;
    logic [7:0] hs;
    b       = in_i.byte_value;
    cnt_inc = cnt_q + 3'd1;
    acc8    = {shift_q[23:0], b};
    acc7    = {shift_q[24:0], b[6:0]};
    trk_inc = trk_q + 16'd1;
    hi      = 8'h00;
    mexp    = 8'h00;
    vdone = 1'b0; verr = 1'b0; evt_done = 1'b0; do_meta_end = 1'b0; take1 = 1'b0;
    hs = hstat_q;
    rp = '0;
    phase_d = phase_q; cnt_d = cnt_q; shift_d = shift_q; skip_d = skip_q;
    ntrk_d = ntrk_q; trk_d = trk_q; left_d = left_q; tick_d = tick_q;
    run_d = run_q; meta_d = meta_q; hstat_d = hstat_q; hdata_d = hdata_q;
    div_d = div_q;

    if (phase_q >= PH_DELTA && phase_q <= PH_TAIL && left_q == 32'd0) begin
      rp.count = 2'd1;
      rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
      rp.r0.error_code = ERR_OVERRUN;
      phase_d = PH_REJECTED; cnt_d = '0; shift_d = '0;
    end else begin
      if (phase_q >= PH_DELTA && phase_q <= PH_TAIL) left_d = left_q - 32'd1;
      // varint step shared by delta and length phases
      if (phase_q == PH_DELTA || phase_q == PH_META_LEN || phase_q == PH_SYSEX_LEN) begin
        shift_d = acc7;
        cnt_d   = cnt_inc;
        vdone   = !b[7];
        verr    = b[7] && (cnt_inc >= 3'(VarintMaxBytes));
      end
      unique case (phase_q)
        PH_HDR_MAGIC, PH_TRK_MAGIC: begin
          unique case (cnt_q[1:0])
            2'd0: mexp = 8'h4d;
            2'd1: mexp = 8'h54;
            2'd2: mexp = (phase_q == PH_HDR_MAGIC) ? 8'h68 : 8'h72;
            default: mexp = (phase_q == PH_HDR_MAGIC) ? 8'h64 : 8'h6b;
          endcase
          if (b != mexp) begin
            rp.count = 2'd1;
            rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
            rp.r0.error_code = (phase_q == PH_HDR_MAGIC) ? ERR_HDR_MAGIC : ERR_TRK_MAGIC;
            phase_d = PH_REJECTED; cnt_d = '0; shift_d = '0;
          end else if (cnt_inc >= 3'd4) begin
            phase_d = (phase_q == PH_HDR_MAGIC) ? PH_HDR_LEN : PH_TRK_LEN;
            cnt_d = '0; shift_d = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        PH_HDR_LEN: begin
          shift_d = acc8; cnt_d = cnt_inc;
          if (cnt_inc >= 3'd4) begin
            cnt_d = '0; shift_d = '0;
            if (acc8 < 32'd6) begin
              rp.count = 2'd1;
              rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
              rp.r0.error_code = ERR_SHORT_HDR;
              phase_d = PH_REJECTED;
            end else begin
              skip_d = acc8 - 32'd6;
              phase_d = PH_HDR_FORMAT;
            end
          end
        end
        PH_HDR_FORMAT, PH_HDR_NTRKS, PH_HDR_DIV: begin
          shift_d = acc8; cnt_d = cnt_inc;
          if (cnt_inc >= 3'd2) begin
            cnt_d = '0; shift_d = '0;
            if (phase_q == PH_HDR_FORMAT) begin
              phase_d = PH_HDR_NTRKS;
            end else if (phase_q == PH_HDR_NTRKS) begin
              ntrk_d = acc8[15:0];
              phase_d = PH_HDR_DIV;
            end else if (ntrk_q == 16'd0 || acc8[15] || acc8[15:0] == 16'd0) begin
              rp.count = 2'd1;
              rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
              rp.r0.error_code = (ntrk_q == 16'd0) ? ERR_ZERO_TRACKS : ERR_DIVISION;
              phase_d = PH_REJECTED;
            end else begin
              div_d = acc8[14:0];
              trk_d = 16'd0;
              rp.count = 2'd1;
              rp.r0 = mk_res(KIND_HEADER, 16'd0, 32'd0);
              rp.r0.ticks_per_quarter = acc8[14:0];
              rp.r0.track_total = ntrk_q;
              phase_d = (skip_q == 32'd0) ? PH_TRK_MAGIC : PH_HDR_SKIP;
            end
          end
        end
        PH_HDR_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) begin
            phase_d = PH_TRK_MAGIC; cnt_d = '0; shift_d = '0;
          end
        end
        PH_TRK_LEN: begin
          shift_d = acc8; cnt_d = cnt_inc;
          if (cnt_inc >= 3'd4) begin
            cnt_d = '0; shift_d = '0;
            left_d = acc8; tick_d = '0; run_d = '0;
            if (acc8 == 32'd0) begin
              rp.count = 2'd1;
              rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
              rp.r0.error_code = ERR_NO_EOT;
              phase_d = PH_REJECTED;
            end else begin
              phase_d = PH_DELTA;
            end
          end
        end
        PH_DELTA: begin
          if (vdone) begin
            tick_d = tick_q + acc7;
            phase_d = PH_STATUS; cnt_d = '0; shift_d = '0;
          end
        end
        PH_STATUS: begin
          cnt_d = '0; shift_d = '0;
          if (b == 8'hff) begin
            run_d = '0; phase_d = PH_META_TYPE;
          end else if (b == 8'hf0 || b == 8'hf7) begin
            run_d = '0; phase_d = PH_SYSEX_LEN;
          end else if (b[7]) begin
            if (b >= 8'hf0) begin
              rp.count = 2'd1;
              rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
              rp.r0.error_code = ERR_SYS_STATUS;
              phase_d = PH_REJECTED;
            end else begin
              hstat_d = b; run_d = b; phase_d = PH_DATA1;
            end
          end else if (!run_q[7]) begin
            rp.count = 2'd1;
            rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
            rp.r0.error_code = ERR_NO_RUNNING;
            phase_d = PH_REJECTED;
          end else begin
            hs = run_q; hstat_d = run_q; take1 = 1'b1;
          end
        end
        PH_DATA1: begin
          if (b[7]) begin
            rp.count = 2'd1;
            rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
            rp.r0.error_code = ERR_DATA_HIGH;
            phase_d = PH_REJECTED; cnt_d = '0; shift_d = '0;
          end else begin
            take1 = 1'b1;
          end
        end
        PH_DATA2: begin
          if (b[7]) begin
            rp.count = 2'd1;
            rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
            rp.r0.error_code = ERR_DATA_HIGH;
            phase_d = PH_REJECTED; cnt_d = '0; shift_d = '0;
          end else begin
            rp.count = 2'd1;
            rp.r0 = mk_res(KIND_CHANNEL, trk_q, tick_q);
            rp.r0.status_value = hstat_q;
            rp.r0.first_data = hdata_q;
            rp.r0.second_data = b[6:0];
            evt_done = 1'b1;
          end
        end
        PH_META_TYPE: begin
          meta_d = b; phase_d = PH_META_LEN; cnt_d = '0; shift_d = '0;
        end
        PH_META_LEN: begin
          if (vdone) begin
            cnt_d = '0; shift_d = '0;
            if (meta_q == 8'h51 && acc7 == 32'd3) phase_d = PH_TEMPO;
            else if (acc7 == 32'd0) do_meta_end = 1'b1;
            else begin
              skip_d = acc7; phase_d = PH_META_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          shift_d = acc8; cnt_d = cnt_inc;
          if (cnt_inc >= 3'd3) begin
            cnt_d = '0; shift_d = '0;
            rp.count = 2'd1;
            if (acc8[23:0] == 24'd0) begin
              rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
              rp.r0.error_code = ERR_ZERO_TEMPO;
              phase_d = PH_REJECTED;
            end else begin
              rp.r0 = mk_res(KIND_TEMPO, trk_q, tick_q);
              rp.r0.tempo_micros = acc8[23:0];
              evt_done = 1'b1;
            end
          end
        end
        PH_META_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) do_meta_end = 1'b1;
        end
        PH_SYSEX_LEN: begin
          if (vdone) begin
            cnt_d = '0; shift_d = '0;
            if (acc7 == 32'd0) evt_done = 1'b1;
            else begin
              skip_d = acc7; phase_d = PH_SYSEX_SKIP;
            end
          end
        end
        PH_SYSEX_SKIP: begin
          skip_d = skip_q - 32'd1;
          if (skip_d == 32'd0) evt_done = 1'b1;
        end
        PH_TAIL: begin
          if (left_d == 32'd0) begin
            trk_d = trk_inc; cnt_d = '0; shift_d = '0;
            if (trk_inc == ntrk_q) begin
              rp.count = 2'd1;
              rp.r0 = mk_res(KIND_FILE_OK, trk_inc, 32'd0);
              phase_d = PH_DONE;
            end else phase_d = PH_TRK_MAGIC;
          end
        end
        PH_DONE: begin
        end
        default: phase_d = PH_REJECTED;
      endcase

      if (verr && !vdone) begin
        rp.count = 2'd1;
        rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
        rp.r0.error_code = ERR_LONG_VARINT;
        phase_d = PH_REJECTED; cnt_d = '0; shift_d = '0;
      end

      if (take1) begin
        hi = hs & 8'hf0;
        hdata_d = b[6:0];
        if (hi == 8'hc0 || hi == 8'hd0) begin
          rp.count = 2'd1;
          rp.r0 = mk_res(KIND_CHANNEL, trk_q, tick_q);
          rp.r0.status_value = hs;
          rp.r0.first_data = b[6:0];
          evt_done = 1'b1;
        end else begin
          phase_d = PH_DATA2; cnt_d = '0; shift_d = '0;
        end
      end

      if (do_meta_end) begin
        if (meta_q == 8'h2f) begin
          // track end, then tail skip, next track, or file done after the last track
          rp.count = 2'd1;
          rp.r0 = mk_res(KIND_TRACK_END, trk_q, tick_q);
          cnt_d = '0; shift_d = '0;
          if (left_d != 32'd0) phase_d = PH_TAIL;
          else begin
            trk_d = trk_inc;
            if (trk_inc == ntrk_q) begin
              rp.count = 2'd2;
              rp.r1 = mk_res(KIND_FILE_OK, trk_inc, 32'd0);
              phase_d = PH_DONE;
            end else phase_d = PH_TRK_MAGIC;
          end
        end else evt_done = 1'b1;
      end

      if (evt_done) begin
        cnt_d = '0; shift_d = '0;
        if (left_d == 32'd0) begin
          rp.count = rp.count + 2'd1;
          if (rp.count == 2'd2) begin
            rp.r1 = mk_res(KIND_REJECTED, trk_q, 32'd0);
            rp.r1.error_code = ERR_NO_EOT;
          end else begin
            rp.r0 = mk_res(KIND_REJECTED, trk_q, 32'd0);
            rp.r0.error_code = ERR_NO_EOT;
          end
          phase_d = PH_REJECTED;
        end else phase_d = PH_DELTA;
      end
    end

    if (in_i.final_byte) begin
      if (phase_d != PH_DONE && phase_d != PH_REJECTED && rp.count != 2'd2) begin
        if (rp.count == 2'd1) begin
          rp.r1 = mk_res(KIND_REJECTED, trk_d, 32'd0);
          rp.r1.error_code = ERR_TRUNCATED;
        end else begin
          rp.r0 = mk_res(KIND_REJECTED, trk_d, 32'd0);
          rp.r0.error_code = ERR_TRUNCATED;
        end
        rp.count = rp.count + 2'd1;
      end
      phase_d = PH_HDR_MAGIC; cnt_d = '0; shift_d = '0; skip_d = '0;
      ntrk_d = '0; trk_d = '0; left_d = '0; tick_d = '0; run_d = '0;
      meta_d = '0; hstat_d = '0; hdata_d = '0; div_d = '0;
    end
    if (rp.count == 2'd1) rp.r0.run_end = 1'b1;
    if (rp.count == 2'd2) rp.r1.run_end = 1'b1;
  end

  assign res_o = rp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_MAGIC; cnt_q <= '0; shift_q <= '0; skip_q <= '0;
      ntrk_q <= '0; trk_q <= '0; left_q <= '0; tick_q <= '0; run_q <= '0;
      meta_q <= '0; hstat_q <= '0; hdata_q <= '0; div_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; shift_q <= shift_d; skip_q <= skip_d;
      ntrk_q <= ntrk_d; trk_q <= trk_d; left_q <= left_d; tick_q <= tick_d;
      run_q <= run_d; meta_q <= meta_d; hstat_q <= hstat_d; hdata_q <= hdata_d;
      div_q <= div_d;
    end
  end
endmodule

>>> rtl/core/mfsp_out_queue.sv
// four-entry result queue with a registered head
`include "assert_macros.svh"
module mfsp_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mfsp_pkg::res_pair_t pair_i,
  output logic                space_o,
  mfsp_out_if.source          out_o
);
  import mfsp_pkg::*;

  res_t       ent_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] fill_q;
  logic       pop;
  logic [1:0] nin;

  assign pop     = out_o.valid && out_o.ready;
  assign nin     = push_i ? pair_i.count : 2'd0;
  // room for two more results after this cycle
  assign space_o = (fill_q <= 3'd2);
  assign out_o.valid = (fill_q != 3'd0);
  assign out_o.data  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; fill_q <= '0;
    end else begin
      rd_q   <= rd_q + {1'b0, pop};
      wr_q   <= wr_q + nin;
      fill_q <= fill_q + {1'b0, nin} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (nin != 2'd0) ent_q[wr_q] <= pair_i.r0;
    if (nin == 2'd2) ent_q[wr_q + 2'd1] <= pair_i.r1;
  end

  `CHK_IMPL(no_overflow, clk_i, rst_ni, push_i, fill_q <= 3'd2)
  `CHK_IMPL(fill_range, clk_i, rst_ni, 1'b1, fill_q <= 3'd4)
  `CHK_NEXT(fill_track, clk_i, rst_ni, !push_i && !pop, $stable(fill_q))
endmodule

>>> rtl/core/midi_file_stream_parser.sv
// midi file stream parser top level
// a byte's results are registered in the result queue and offered from the cycle after it is accepted
// throughput: one byte per cycle while input ready is high; a byte yields up to two results, drained one per
// cycle while output ready is high; input ready drops while the four-entry result queue holds more than two results
// reset: asynchronous active low, parser returns to expecting the header magic
// the final byte also returns all parse state to its reset values
module midi_file_stream_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfsp_in_if.sink    in_i,
  mfsp_out_if.source out_o
);
  import mfsp_pkg::*;

  logic      step;
  logic      space;
  res_pair_t pair;

  assign in_i.ready = space;
  assign step = in_i.valid && space;

  mfsp_decoder u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_i.data),
    .res_o  (pair)
  );

  mfsp_out_queue u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .pair_i  (pair),
    .space_o (space),
    .out_o   (out_o)
  );
endmodule

>>> test/midi_file_stream_parser_tb.sv
// testbench for the midi file stream parser: directed table, extreme cases, then random files checked by a predictor
module midi_file_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfsp_pkg::*;

  localparam int StallLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  mfsp_in_if  byte_ch ();
  mfsp_out_if event_ch ();

  midi_file_stream_parser uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (event_ch)
  );

  // predictor state
  logic [4:0]  ph;
  logic [2:0]  fcnt;
  logic [31:0] fshift;
  logic [31:0] skip_left;
  logic [15:0] ntracks;
  logic [15:0] trk;
  logic [31:0] bytes_left;
  logic [31:0] tick_acc;
  logic [7:0]  run_st;
  logic [7:0]  meta_k;
  logic [7:0]  held_st;
  logic [6:0]  held_d;
  logic [14:0] division;
  res_t        step_res[$];

  res_t expected_events[$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  int   sink_gap = 0;
  bit   calm = 1'b0;
  bit   hold_sink = 1'b0;

  // stimulus: byte, final flag, typed-in expectation (optional)
  typedef struct {
    logic [7:0] b;
    logic       fin;
    bit         has_exp;
    res_t       exp;
  } row_t;
  row_t directed[$];
  logic [8:0] byte_queue[$];

  task automatic report_mismatch(input string what, input res_t got, input res_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  function automatic void parser_clear();
    ph = PH_HDR_MAGIC; fcnt = 0; fshift = 0; skip_left = 0; ntracks = 0; trk = 0;
    bytes_left = 0; tick_acc = 0; run_st = 0; meta_k = 0; held_st = 0; held_d = 0;
    division = 0;
  endfunction

  function automatic void go(logic [4:0] p);
    ph = p; fcnt = 0; fshift = 0;
  endfunction

  function automatic void push_res(kind_e k, logic [31:0] tick);
    res_t r;
    r = '0;
    r.result_kind = k; r.track_number = trk; r.tick_time = tick;
    if (step_res.size() < 2) step_res.insert(step_res.size(), r);
  endfunction

  function automatic void reject_with(err_e e);
    if (step_res.size() < 2) begin
      push_res(KIND_REJECTED, 0);
      step_res[step_res.size()-1].error_code = e;
    end
    go(PH_REJECTED);
  endfunction

  function automatic void shift_byte(logic [7:0] b);
    fshift = (fshift << 8) | b;
    fcnt = fcnt + 1;
  endfunction

  // 1 complete, 0 more, -1 rejected
  function automatic int take_varint(logic [7:0] b);
    fshift = (fshift << 7) | b[6:0];
    fcnt = fcnt + 1;
    if (!b[7]) return 1;
    if (fcnt >= VarintMaxBytes) begin
      reject_with(ERR_LONG_VARINT);
      return -1;
    end
    return 0;
  endfunction

  function automatic void advance_track();
    trk = trk + 1;
    if (trk == ntracks) begin
      push_res(KIND_FILE_OK, 0);
      go(PH_DONE);
    end else go(PH_TRK_MAGIC);
  endfunction

  function automatic void after_event();
    if (bytes_left == 0) reject_with(ERR_NO_EOT);
    else go(PH_DELTA);
  endfunction

  function automatic void after_meta();
    if (meta_k == 8'h2f) begin
      push_res(KIND_TRACK_END, tick_acc);
      if (bytes_left == 0) advance_track();
      else go(PH_TAIL);
    end else after_event();
  endfunction

  function automatic void first_data_in(logic [7:0] d);
    held_d = d[6:0];
    if (held_st[7:4] == 4'hc || held_st[7:4] == 4'hd) begin
      push_res(KIND_CHANNEL, tick_acc);
      step_res[step_res.size()-1].status_value = held_st;
      step_res[step_res.size()-1].first_data = held_d;
      after_event();
    end else go(PH_DATA2);
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [7:0] magic[4];
    int v;
    if (ph >= PH_DELTA && ph <= PH_TAIL) begin
      if (bytes_left == 0) begin
        reject_with(ERR_OVERRUN);
        return;
      end
      bytes_left--;
    end
    case (ph)
      PH_HDR_MAGIC, PH_TRK_MAGIC: begin
        if (ph == PH_HDR_MAGIC) magic = '{8'h4d, 8'h54, 8'h68, 8'h64};
        else magic = '{8'h4d, 8'h54, 8'h72, 8'h6b};
        if (b != magic[fcnt[1:0]]) begin
          reject_with(ph == PH_HDR_MAGIC ? ERR_HDR_MAGIC : ERR_TRK_MAGIC);
          return;
        end
        fcnt++;
        if (fcnt >= 4) go(ph == PH_HDR_MAGIC ? PH_HDR_LEN : PH_TRK_LEN);
      end
      PH_HDR_LEN: begin
        shift_byte(b);
        if (fcnt >= 4) begin
          if (fshift < 6) reject_with(ERR_SHORT_HDR);
          else begin
            skip_left = fshift - 6;
            go(PH_HDR_FORMAT);
          end
        end
      end
      PH_HDR_FORMAT: begin
        shift_byte(b);
        if (fcnt >= 2) go(PH_HDR_NTRKS);
      end
      PH_HDR_NTRKS: begin
        shift_byte(b);
        if (fcnt >= 2) begin
          ntracks = fshift[15:0];
          go(PH_HDR_DIV);
        end
      end
      PH_HDR_DIV: begin
        shift_byte(b);
        if (fcnt >= 2) begin
          if (ntracks == 0) reject_with(ERR_ZERO_TRACKS);
          else if (fshift[15] || fshift[15:0] == 0) reject_with(ERR_DIVISION);
          else begin
            division = fshift[14:0];
            trk = 0;
            push_res(KIND_HEADER, 0);
            step_res[step_res.size()-1].ticks_per_quarter = division;
            step_res[step_res.size()-1].track_total = ntracks;
            go(skip_left == 0 ? PH_TRK_MAGIC : PH_HDR_SKIP);
          end
        end
      end
      PH_HDR_SKIP: begin
        skip_left--;
        if (skip_left == 0) go(PH_TRK_MAGIC);
      end
      PH_TRK_LEN: begin
        shift_byte(b);
        if (fcnt >= 4) begin
          bytes_left = fshift;
          tick_acc = 0;
          run_st = 0;
          if (bytes_left == 0) reject_with(ERR_NO_EOT);
          else go(PH_DELTA);
        end
      end
      PH_DELTA: begin
        if (take_varint(b) == 1) begin
          tick_acc += fshift;
          go(PH_STATUS);
        end
      end
      PH_STATUS: begin
        if (b == 8'hff) begin
          run_st = 0; go(PH_META_TYPE);
        end else if (b == 8'hf0 || b == 8'hf7) begin
          run_st = 0; go(PH_SYSEX_LEN);
        end else if (b[7]) begin
          if (b >= 8'hf0) reject_with(ERR_SYS_STATUS);
          else begin
            held_st = b; run_st = b; go(PH_DATA1);
          end
        end else if (run_st < 8'h80) reject_with(ERR_NO_RUNNING);
        else begin
          held_st = run_st;
          first_data_in(b);
        end
      end
      PH_DATA1: begin
        if (b[7]) reject_with(ERR_DATA_HIGH);
        else first_data_in(b);
      end
      PH_DATA2: begin
        if (b[7]) reject_with(ERR_DATA_HIGH);
        else begin
          push_res(KIND_CHANNEL, tick_acc);
          step_res[step_res.size()-1].status_value = held_st;
          step_res[step_res.size()-1].first_data = held_d;
          step_res[step_res.size()-1].second_data = b[6:0];
          after_event();
        end
      end
      PH_META_TYPE: begin
        meta_k = b; go(PH_META_LEN);
      end
      PH_META_LEN: begin
        v = take_varint(b);
        if (v == 1) begin
          if (meta_k == 8'h51 && fshift == 3) go(PH_TEMPO);
          else if (fshift == 0) after_meta();
          else begin
            skip_left = fshift; go(PH_META_SKIP);
          end
        end
      end
      PH_TEMPO: begin
        shift_byte(b);
        if (fcnt >= 3) begin
          if (fshift[23:0] == 0) reject_with(ERR_ZERO_TEMPO);
          else begin
            push_res(KIND_TEMPO, tick_acc);
            step_res[step_res.size()-1].tempo_micros = fshift[23:0];
            after_event();
          end
        end
      end
      PH_META_SKIP: begin
        skip_left--;
        if (skip_left == 0) after_meta();
      end
      PH_SYSEX_LEN: begin
        v = take_varint(b);
        if (v == 1) begin
          if (fshift == 0) after_event();
          else begin
            skip_left = fshift; go(PH_SYSEX_SKIP);
          end
        end
      end
      PH_SYSEX_SKIP: begin
        skip_left--;
        if (skip_left == 0) after_event();
      end
      PH_TAIL: if (bytes_left == 0) advance_track();
      PH_DONE: ;
      default: ph = PH_REJECTED;
    endcase
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    step_res.delete();
    parse_byte(b);
    if (fin) begin
      if (ph != PH_DONE && ph != PH_REJECTED) reject_with(ERR_TRUNCATED);
      parser_clear();
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].run_end = 1'b1;
  endfunction

  // ---------------- stimulus building ----------------
  function automatic void add_bytes(input logic [7:0] bs[$]);
    foreach (bs[i]) byte_queue.insert(byte_queue.size(), {bs[i], 1'b0});
  endfunction

  function automatic void end_file();
    byte_queue[byte_queue.size()-1][0] = 1'b1;
  endfunction

  function automatic void add_header(logic [15:0] ntrk, logic [15:0] div, int extra);
    logic [31:0] len;
    len = 6 + extra;
    add_bytes('{8'h4d, 8'h54, 8'h68, 8'h64, len[31:24], len[23:16], len[15:8], len[7:0],
                8'($urandom), 8'($urandom), ntrk[15:8], ntrk[7:0], div[15:8], div[7:0]});
    for (int i = 0; i < extra; i++) byte_queue.insert(byte_queue.size(), {8'($urandom), 1'b0});
  endfunction

  function automatic void add_varint(logic [31:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--)
      byte_queue.insert(byte_queue.size(), {(i != 0), 7'((v >> (7 * i)) & 32'h7f), 1'b0});
  endfunction

  // one random event body into a temporary list
  function automatic void gen_event(ref logic [7:0] body[$], input bit have_run);
    int sel, n;
    logic [31:0] d;
    logic [7:0] st;
    d = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
    n = (d < 128) ? 1 : (d < 16384) ? 2 : (d < 2097152) ? 3 : 4;
    if (d >= 32'h0fffffff) d = d & 32'h0fffffff;
    n = (d < 128) ? 1 : (d < 16384) ? 2 : (d < 2097152) ? 3 : 4;
    for (int i = n - 1; i >= 0; i--)
      body.insert(body.size(), {(i != 0), 7'((d >> (7 * i)) & 32'h7f)});
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      st = 8'($urandom_range(8'h80, 8'hef));
      if (!(have_run && $urandom_range(0, 2) == 0)) body.insert(body.size(), st);
      else st = 8'h90;
      body.insert(body.size(), {1'b0, 7'($urandom)});
      body.insert(body.size(), {1'b0, 7'($urandom)});
    end else if (sel == 6) begin
      body.insert(body.size(), 8'hff); body.insert(body.size(), 8'h51);
      body.insert(body.size(), 8'h03);
      body.insert(body.size(), 8'($urandom)); body.insert(body.size(), 8'($urandom));
      body.insert(body.size(), 8'($urandom_range(1, 255)));
    end else if (sel == 7) begin
      body.insert(body.size(), 8'hff);
      body.insert(body.size(), 8'($urandom_range(0, 8'h7f)) == 8'h2f ? 8'h01 :
                               8'($urandom_range(0, 8'h7f)));
      n = $urandom_range(0, 3);
      body.insert(body.size(), 8'(n));
      for (int i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
    end else begin
      body.insert(body.size(), $urandom_range(0, 1) ? 8'hf0 : 8'hf7);
      n = $urandom_range(0, 3);
      body.insert(body.size(), 8'(n));
      for (int i = 0; i < n; i++) body.insert(body.size(), 8'($urandom));
    end
  endfunction

  function automatic void add_track(int nev, int tail, bit corrupt);
    logic [7:0] body[$];
    logic [31:0] len;
    for (int e = 0; e < nev; e++) gen_event(body, 1'b0);
    body.insert(body.size(), 8'h00); body.insert(body.size(), 8'hff);
    body.insert(body.size(), 8'h2f); body.insert(body.size(), 8'h00);
    for (int i = 0; i < tail; i++) body.insert(body.size(), 8'($urandom));
    // one random byte replacement exercises the rejection paths
    if (corrupt) body[$urandom_range(0, body.size()-1)] = 8'($urandom);
    len = body.size();
    if (corrupt && $urandom_range(0, 3) == 0) len = len - $urandom_range(0, 3);
    add_bytes('{8'h4d, 8'h54, 8'h72, 8'h6b, len[31:24], len[23:16], len[15:8], len[7:0]});
    foreach (body[i]) byte_queue.insert(byte_queue.size(), {body[i], 1'b0});
  endfunction

  function automatic res_t exp_err(err_e e, logic [15:0] t);
    res_t r;
    r = '0;
    r.result_kind = KIND_REJECTED; r.track_number = t; r.error_code = e; r.run_end = 1'b1;
    return r;
  endfunction

  function automatic void add_row(logic [7:0] b, logic fin, bit has, res_t e);
    row_t r;
    r.b = b; r.fin = fin; r.has_exp = has; r.exp = e;
    directed.insert(directed.size(), r);
  endfunction

  // ---------------- driving ----------------
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit has, input res_t e);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data <= '{byte_value: b, final_byte: fin};
    do @(posedge clk_i); while (!byte_ch.ready);
    predict_byte(b, fin);
    if (has && (step_res.size() != 1 || step_res[0] != e))
      report_mismatch("directed row", step_res.size() ? step_res[0] : '0, e);
    foreach (step_res[i]) expected_events.insert(expected_events.size(), step_res[i]);
  endtask

  always @(posedge clk_i) begin
    if (event_ch.valid && event_ch.ready) begin
      if (expected_events.size() == 0) report_mismatch("unexpected", event_ch.data, '0);
      else begin
        res_t want;
        want = expected_events.pop_front();
        if (event_ch.data != want) report_mismatch("event", event_ch.data, want);
      end
    end
  end

  // receiver idles in random bursts
  always @(posedge clk_i) begin
    if (hold_sink) event_ch.ready <= 1'b0;
    else if (calm) event_ch.ready <= 1'b1;
    else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      event_ch.ready <= (sink_gap == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(1, 5);
      event_ch.ready <= 1'b0;
    end else event_ch.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    res_t none;
    int ntrk;
    none = '0;
    byte_ch.valid = 1'b0;
    byte_ch.data = '0;
    event_ch.ready = 1'b0;
    parser_clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_row(8'h00, 1'b0, 1, exp_err(ERR_HDR_MAGIC, 0));
    add_row(8'hff, 1'b1, 0, none);
    add_row(8'h4d, 1'b1, 1, exp_err(ERR_TRUNCATED, 0));
    begin
      logic [7:0] h[$];
      h = '{8'h4d, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00};
      foreach (h[i]) add_row(h[i], 0, 0, none);
      add_row(8'h05, 1'b0, 1, exp_err(ERR_SHORT_HDR, 0));
      add_row(8'h00, 1'b1, 0, none);
      h = '{8'h4d, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06, 8'hff, 8'hff,
            8'h00, 8'h00, 8'h00};
      foreach (h[i]) add_row(h[i], 0, 0, none);
      add_row(8'h60, 1'b0, 1, exp_err(ERR_ZERO_TRACKS, 0));
      add_row(8'hff, 1'b1, 0, none);
    end
    foreach (directed[i]) send_byte(directed[i].b, directed[i].fin, directed[i].has_exp,
                                    directed[i].exp);

    // extremes handled through the predictor
    add_header(16'h0001, 16'h8000, 0); end_file();
    add_header(16'h0001, 16'h0000, 0); end_file();
    add_header(16'h0001, 16'h7fff, 3);
    byte_queue.insert(byte_queue.size(), {8'h4d, 1'b0});
    byte_queue.insert(byte_queue.size(), {8'h54, 1'b0});
    byte_queue.insert(byte_queue.size(), {8'h72, 1'b0});
    byte_queue.insert(byte_queue.size(), {8'h6b, 1'b0});
    add_bytes('{8'h00, 8'h00, 8'h00, 8'h00}); end_file();
    add_header(16'h0001, 16'h0001, 0);
    add_bytes('{8'h4d, 8'h54, 8'h72, 8'h6b, 8'h00, 8'h00, 8'h00, 8'd24});
    add_varint(32'h0fffffff, 4);
    add_bytes('{8'hff, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00});
    add_bytes('{8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00});
    end_file();
    add_header(16'hffff, 16'h0060, 0);
    add_bytes('{8'h4d, 8'h54, 8'h72, 8'h6b, 8'h00, 8'h00, 8'h00, 8'd16, 8'h00, 8'hc5, 8'h7f,
                8'h00, 8'h10, 8'h00, 8'h00, 8'hf3, 8'h00, 8'hff, 8'h2f, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00});
    end_file();
    add_bytes('{8'h00, 8'h00, 8'h00, 8'h00}); end_file();
    while (byte_queue.size() > 0) begin
      logic [8:0] x;
      x = byte_queue.pop_front();
      send_byte(x[8:1], x[0], 0, none);
    end

    // random files, mostly well formed
    while (byte_queue.size() < 1600) begin
      bit bad;
      bad = ($urandom_range(0, 4) == 0);
      ntrk = $urandom_range(1, 3);
      add_header(16'(ntrk), 16'($urandom_range(1, 16'h7fff)), $urandom_range(0, 5) == 0 ?
                 $urandom_range(1, 3) : 0);
      for (int t = 0; t < ntrk; t++)
        add_track($urandom_range(0, 8), $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0,
                  bad && t == ntrk - 1);
      if ($urandom_range(0, 3) == 0)
        for (int i = $urandom_range(1, 3); i > 0; i--)
          byte_queue.insert(byte_queue.size(), {8'($urandom), 1'b0});
      if (bad && $urandom_range(0, 1)) void'(byte_queue.pop_back());
      end_file();
    end
    // also a raw noise file
    for (int i = 0; i < 20; i++) byte_queue.insert(byte_queue.size(), {8'($urandom), 1'b0});
    end_file();

    while (byte_queue.size() > 0) begin
      logic [8:0] x;
      if (byte_queue.size() == 1200) begin
        fork
          begin
            hold_sink = 1'b1;
            repeat (60) @(posedge clk_i);
            hold_sink = 1'b0;
          end
        join_none
      end
      if (byte_queue.size() == 300) calm = 1'b1;
      x = byte_queue.pop_front();
      send_byte(x[8:1], x[0], 0, none);
    end
    byte_ch.valid <= 1'b0;
    while (expected_events.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
